### src/gpu_command_packet_parser_assert.svh
// ----------------------------------------------------------------------------
// gpu command packet parser assertion macros
// shared concurrent assertion forms, clocked on clk, disabled during rst
// ----------------------------------------------------------------------------
`ifndef GPU_COMMAND_PACKET_PARSER_ASSERT_SVH
`define GPU_COMMAND_PACKET_PARSER_ASSERT_SVH

// same-cycle implication
`define GCPP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gcpp same-cycle check failed");

// next-cycle implication
`define GCPP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gcpp next-cycle check failed");

`endif

### src/gcpp_pkg.sv
// ----------------------------------------------------------------------------
// gcpp_pkg
// types and constants shared by the command packet parser modules
// ----------------------------------------------------------------------------
package gcpp_pkg;

  localparam int unsigned AddrWidth = 32;

  localparam logic [2:0] KIND_TYPE0  = 3'd0;
  localparam logic [2:0] KIND_TYPE3  = 3'd1;
  localparam logic [2:0] KIND_FILLER = 3'd2;
  localparam logic [2:0] KIND_REGVAL = 3'd3;
  localparam logic [2:0] KIND_BODY3  = 3'd4;

  localparam logic [31:0] FILL_DEADBEEF = 32'hDEADBEEF;
  localparam logic [31:0] FILL_ONES     = 32'hFFFFFFFF;
  localparam logic [31:0] FILL_F8FF     = 32'hFFFFF8FF;
  localparam logic [31:0] FILL_SEVENS   = 32'h77777777;
  localparam logic [31:0] FILL_ZERO     = 32'h00000000;

  localparam logic [1:0]  HDR_TYPE2     = 2'd2;
  localparam logic [1:0]  HDR_TYPE3     = 2'd3;
  localparam logic [6:0]  OPC_NOP       = 7'h7F;
  localparam logic [14:0] MAX_REG_COUNT = 15'd256;
  localparam logic [15:0] MAX_REG_BASE  = 16'hC000;

  typedef struct packed {
    logic [31:0]          word;
    logic                 first_of_range;
    logic                 last_of_range;
    logic [AddrWidth-1:0] range_base;
  } cmd_beat_t;

  typedef struct packed {
    logic [2:0]           kind;
    logic [31:0]          data;
    logic [AddrWidth-1:0] packet_address;
    logic [6:0]           opcode;
    logic                 predicate;
    logic [14:0]          word_count;
    logic [15:0]          register_base;
    logic [13:0]          body_index;
    logic                 last_of_packet;
    logic                 truncated;
  } res_beat_t;

  function automatic logic [31:0] swap32(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage

### src/gcpp_in_reg.sv
// ----------------------------------------------------------------------------
// gcpp_in_reg
// input register for command beats, stalls the sender when the stage is held
// ----------------------------------------------------------------------------
module gcpp_in_reg
  import gcpp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_stall,
  input  cmd_beat_t cmd_beat,
  input  logic      advance,
  output logic      held_valid,
  output cmd_beat_t held_beat
);

  assign cmd_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!cmd_stall) begin
      held_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!cmd_stall && cmd_valid) begin
      held_beat <= cmd_beat;
    end
  end

endmodule

### src/gcpp_parse.sv
// ----------------------------------------------------------------------------
// gcpp_parse
// classifies one swapped dword against the open packet and tracks its state
// ----------------------------------------------------------------------------
`include "gpu_command_packet_parser_assert.svh"

module gcpp_parse
  import gcpp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  cmd_beat_t beat,
  output res_beat_t res
);

  logic [AddrWidth-1:0] next_address;
  logic [AddrWidth-1:0] header_address;
  logic [14:0]          words_left;
  logic                 in_type3;
  logic [6:0]           held_opcode;
  logic                 held_predicate;
  logic [14:0]          held_count;
  logic [15:0]          held_register_base;
  logic [13:0]          next_index;

  logic [AddrWidth-1:0] next_address_next;
  logic [AddrWidth-1:0] header_address_next;
  logic [14:0]          words_left_next;
  logic                 in_type3_next;
  logic [6:0]           held_opcode_next;
  logic                 held_predicate_next;
  logic [14:0]          held_count_next;
  logic [15:0]          held_register_base_next;
  logic [13:0]          next_index_next;

  logic [31:0]          w;
  logic [AddrWidth-1:0] addr;
  logic [14:0]          wl;
  logic [14:0]          wl_dec;
  logic [14:0]          hdr_count;
  logic                 filler;

  always_comb begin
    w         = swap32(beat.word);
    addr      = beat.first_of_range ? beat.range_base : next_address;
    wl        = beat.first_of_range ? 15'd0 : words_left;
    wl_dec    = wl - 15'd1;
    hdr_count = {1'b0, w[29:16]} + 15'd1;

    filler = (w == FILL_DEADBEEF) || (w == FILL_ONES) || (w == FILL_F8FF) ||
             (w == FILL_SEVENS) || (w == FILL_ZERO) || (w[31:30] == HDR_TYPE2);
    if (w[31:30] == HDR_TYPE3) begin
      if (w[14:8] == OPC_NOP) begin
        filler = 1'b1;
      end
    end else if ((hdr_count > MAX_REG_COUNT) || (w[15:0] > MAX_REG_BASE)) begin
      filler = 1'b1;
    end

    next_address_next       = addr + AddrWidth'(4);
    header_address_next     = header_address;
    words_left_next         = wl;
    in_type3_next           = in_type3;
    held_opcode_next        = held_opcode;
    held_predicate_next     = held_predicate;
    held_count_next         = held_count;
    held_register_base_next = held_register_base;
    next_index_next         = next_index;

    res                = '0;
    res.data           = w;
    res.packet_address = addr;

    if (wl != 15'd0) begin
      res.kind           = in_type3 ? KIND_BODY3 : KIND_REGVAL;
      res.opcode         = held_opcode;
      res.predicate      = held_predicate;
      res.word_count     = held_count;
      res.register_base  = held_register_base;
      res.body_index     = next_index;
      res.truncated      = beat.last_of_range && (wl_dec != 15'd0);
      res.last_of_packet = beat.last_of_range || (wl_dec == 15'd0);
      res.packet_address = header_address;
      next_index_next    = next_index + 14'd1;
      words_left_next    = beat.last_of_range ? 15'd0 : wl_dec;
    end else begin
      header_address_next = addr;
      if (filler) begin
        res.kind           = KIND_FILLER;
        res.last_of_packet = 1'b1;
      end else begin
        if (w[31:30] == HDR_TYPE3) begin
          res.kind      = KIND_TYPE3;
          res.opcode    = w[14:8];
          res.predicate = w[0];
          in_type3_next = 1'b1;
        end else begin
          res.kind          = KIND_TYPE0;
          res.register_base = w[15:0];
          in_type3_next     = 1'b0;
        end
        res.word_count          = hdr_count;
        held_opcode_next        = res.opcode;
        held_predicate_next     = res.predicate;
        held_count_next         = hdr_count;
        held_register_base_next = res.register_base;
        next_index_next         = 14'd0;
        res.last_of_packet      = beat.last_of_range;
        res.truncated           = beat.last_of_range;
        words_left_next         = beat.last_of_range ? 15'd0 : hdr_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_address       <= '0;
      header_address     <= '0;
      words_left         <= '0;
      in_type3           <= 1'b0;
      held_opcode        <= '0;
      held_predicate     <= 1'b0;
      held_count         <= '0;
      held_register_base <= '0;
      next_index         <= '0;
    end else if (fire) begin
      next_address       <= next_address_next;
      header_address     <= header_address_next;
      words_left         <= words_left_next;
      in_type3           <= in_type3_next;
      held_opcode        <= held_opcode_next;
      held_predicate     <= held_predicate_next;
      held_count         <= held_count_next;
      held_register_base <= held_register_base_next;
      next_index         <= next_index_next;
    end
  end

  // a truncated packet always closes on this beat
  `GCPP_ASSERT_NOW(a_trunc_closes, fire && res.truncated, res.last_of_packet)
  // a filler carries no count and is a packet of its own
  `GCPP_ASSERT_NOW(a_filler_alone, fire && (res.kind == KIND_FILLER), res.last_of_packet && (res.word_count == 15'd0))
  // an open header loads the full body count
  `GCPP_ASSERT_NEXT(a_hdr_opens, fire && !res.last_of_packet && ((res.kind == KIND_TYPE0) || (res.kind == KIND_TYPE3)), (words_left == held_count) && (words_left != 15'd0))

endmodule

### src/gcpp_out_reg.sv
// ----------------------------------------------------------------------------
// gcpp_out_reg
// result register, holds a beat until the receiver takes it
// ----------------------------------------------------------------------------
module gcpp_out_reg
  import gcpp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      load_valid,
  input  res_beat_t load_beat,
  output logic      advance,
  output logic      res_valid,
  input  logic      res_stall,
  output res_beat_t res_beat
);

  assign advance = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load_valid) begin
      res_beat <= load_beat;
    end
  end

endmodule

### src/gpu_command_packet_parser.sv
// ----------------------------------------------------------------------------
// gpu_command_packet_parser
// splits a command dword stream into packets and tags every beat
// ----------------------------------------------------------------------------
// usage
//   command channel: cmd_valid/cmd_stall with word, first_of_range,
//   last_of_range and range_base; one dword per beat, as read from memory
//   result channel: res_valid/res_stall; exactly one result beat per
//   command beat, in order, carrying the swapped dword and its packet tags
//   path: a taken beat waits in the input register, is parsed combinationally
//   and is loaded into the result register, where the receiver takes it
//   throughput: one beat per cycle while res_stall is low, set by the single
//   parse stage between the input and result registers
//   reset: rst (synchronous) empties both registers and clears the packet
//   state, so the first beat is read as a header at address zero unless it
//   starts a range
//   stall: while res_stall holds a full result register, the parse stage
//   waits and cmd_stall rises once the input register is also full
// ----------------------------------------------------------------------------
module gpu_command_packet_parser
  import gcpp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  logic [31:0] word,
  input  logic        first_of_range,
  input  logic        last_of_range,
  input  logic [31:0] range_base,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [2:0]  kind,
  output logic [31:0] data,
  output logic [31:0] packet_address,
  output logic [6:0]  opcode,
  output logic        predicate,
  output logic [14:0] word_count,
  output logic [15:0] register_base,
  output logic [13:0] body_index,
  output logic        last_of_packet,
  output logic        truncated
);

  cmd_beat_t cmd_beat;
  cmd_beat_t held_beat;
  logic      held_valid;
  logic      advance;
  res_beat_t parsed;
  res_beat_t res_beat;

  assign cmd_beat = '{word: word, first_of_range: first_of_range,
                      last_of_range: last_of_range, range_base: range_base};

  gcpp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd_beat   (cmd_beat),
    .advance    (advance),
    .held_valid (held_valid),
    .held_beat  (held_beat)
  );

  gcpp_parse u_parse (
    .clk  (clk),
    .rst  (rst),
    .fire (held_valid && advance),
    .beat (held_beat),
    .res  (parsed)
  );

  gcpp_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load_valid (held_valid),
    .load_beat  (parsed),
    .advance    (advance),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_beat   (res_beat)
  );

  assign kind           = res_beat.kind;
  assign data           = res_beat.data;
  assign packet_address = res_beat.packet_address;
  assign opcode         = res_beat.opcode;
  assign predicate      = res_beat.predicate;
  assign word_count     = res_beat.word_count;
  assign register_base  = res_beat.register_base;
  assign body_index     = res_beat.body_index;
  assign last_of_packet = res_beat.last_of_packet;
  assign truncated      = res_beat.truncated;

endmodule
